@@ rtl/core/mrnn_pkg.sv @@
package mrnn_pkg;

   localparam int MAX_POINTS_DEF  = 32;
   localparam int MAX_ROUTES_DEF  = 8;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 8;

   localparam int ID_W    = 5;
   localparam int RIDX_W  = 3;
   localparam int LEG_W   = 25;
   localparam int SUM_W   = 30;
   localparam int NR_W    = 4;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,      // taking words
      ST_RSTART,    // begin a route
      ST_SCAN_RD,   // read candidate slot
      ST_SCAN_CMP,  // squared distance to candidate
      ST_SCAN_ACC,  // keep best
      ST_PICK_RD,   // read chosen slot
      ST_LEG_CMP,   // distance to chosen slot
      ST_SQRT,      // root of chosen distance
      ST_EMIT       // present result
   } state_type;

endpackage

@@ rtl/core/multi_route_nearest_neighbor.sv @@
// Channel   Direction  Ports
// request   in         start, req_city_id, req_x_coord, req_y_coord, req_last_city; busy is out
// response  out        rsp_valid, rsp_route_index, rsp_visit_id, rsp_leg_length,
//                      rsp_route_length, rsp_total_length, rsp_end_of_route, rsp_last
// csr       in         csr_we, csr_wdata (num_routes)
//
// Loading takes one word per cycle while busy is low. The last word starts the solve. Each
// route opens with ST_RSTART; each result then costs a scan of ST_SCAN_RD, ST_SCAN_CMP and
// ST_SCAN_ACC per city slot of the route (visited or not, at least one pass), a pick state,
// a distance state, a bit-serial square root and an emit state.
// busy is high through the solve. Reset is synchronous and clears control state only;
// the receiver cannot stall, so each result shows one cycle.
module multi_route_nearest_neighbor #(
   parameter int MAX_POINTS  = mrnn_pkg::MAX_POINTS_DEF,
   parameter int MAX_ROUTES  = mrnn_pkg::MAX_ROUTES_DEF,
   parameter int COORD_WIDTH = mrnn_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = mrnn_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mrnn_pkg::ID_W-1:0]     req_city_id,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  logic                          req_last_city,
   input  logic                          csr_we,
   input  logic [mrnn_pkg::NR_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   output logic [mrnn_pkg::RIDX_W-1:0]   rsp_route_index,
   output logic [mrnn_pkg::ID_W-1:0]     rsp_visit_id,
   output logic [mrnn_pkg::LEG_W-1:0]    rsp_leg_length,
   output logic [mrnn_pkg::SUM_W-1:0]    rsp_route_length,
   output logic [mrnn_pkg::SUM_W-1:0]    rsp_total_length,
   output logic                          rsp_end_of_route,
   output logic                          rsp_last
);
   import mrnn_pkg::*;

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int DW   = COORD_WIDTH + 1;
   localparam int SQW  = 2 * DW + 1;
   localparam int VW   = 2 * ((SQW + 1) / 2);
   localparam int RSTEPS = VW / 2 + FRAC_BITS;
   localparam int RTW  = RSTEPS;
   localparam int REMW = RSTEPS + 2;
   localparam int SCW  = $clog2(RSTEPS + 1);
   localparam int RW   = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int RCW  = $clog2(MAX_ROUTES + 1);
   localparam int PW   = ID_W + 2 * COORD_WIDTH;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   state_type state_ff, state_in;

   // point memory, slot 0 is the depot
   logic [PW-1:0] pmem [MAX_POINTS];
   logic [PW-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   logic [MAX_POINTS-1:0] vis_ff, vis_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          depot_ff, depot_in;
   logic [NR_W-1:0] nr_ff;
   logic [RCW-1:0]  routes_ff, routes_in;
   logic [RW-1:0]   route_ff, route_in;
   logic [CW-1:0]   cand_ff, cand_in;     // city index (slot-1)
   logic            home_ff, home_in;     // depot word lands in ST_SCAN_RD
   logic signed [COORD_WIDTH-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic            found_ff, found_in;
   logic [SQW-1:0]  bestd_ff, bestd_in, d_ff, d_in;
   logic [AW-1:0]   best_ff, best_in;
   logic [RTW-1:0]  root_ff, root_in;
   logic [REMW-1:0] rem_ff, rem_in;
   logic [VW-1:0]   val_ff, val_in;
   logic [SCW-1:0]  step_ff, step_in;
   logic [SUM_W-1:0] rsum_ff, rsum_in, tsum_ff, tsum_in;
   logic            endr_ff, endr_in;

   logic accept;
   logic [CW-1:0] ncity;
   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0] adx, ady;
   logic [2*DW-1:0] sqx, sqy;
   logic [SQW-1:0] dsq;
   logic [REMW-1:0] trial, rem_sh;
   logic [LEG_W-1:0] leg;
   logic [SUM_W:0] radd, tadd;
   logic [CW:0] nxt_cand;
   logic [NR_W-1:0] nr_eff;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_LOAD);
   assign ncity  = cnt_ff - CW'(1);
   assign leg    = LEG_W'(root_ff);
   assign nxt_cand = (CW+1)'(cand_ff) + (CW+1)'(routes_ff);

   // squared distance of current point to memory word
   assign dx  = DW'(cx_ff) - DW'($signed(rd_ff[2*COORD_WIDTH-1:COORD_WIDTH]));
   assign dy  = DW'(cy_ff) - DW'($signed(rd_ff[COORD_WIDTH-1:0]));
   assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign sqx = (2*DW)'(adx) * (2*DW)'(adx);
   assign sqy = (2*DW)'(ady) * (2*DW)'(ady);
   assign dsq = SQW'(sqx) + SQW'(sqy);

   // root step
   assign rem_sh = {rem_ff[REMW-3:0], val_ff[VW-1:VW-2]};
   assign trial  = {root_ff, 2'b01};
   assign radd   = (SUM_W+1)'(rsum_ff) + (SUM_W+1)'(leg);
   assign tadd   = (SUM_W+1)'(tsum_ff) + (SUM_W+1)'(leg);
   assign nr_eff = (nr_ff == '0) ? NR_W'(1) : nr_ff;

   // memory access
   always_comb begin
      wr_en   = accept && (depot_ff || cnt_ff < CW'(MAX_POINTS));
      wr_addr = depot_ff ? '0 : AW'(cnt_ff);
      case (state_ff)
         ST_RSTART:  rd_addr = '0;
         ST_PICK_RD: rd_addr = found_ff ? best_ff : '0;
         ST_LEG_CMP, ST_SQRT, ST_EMIT: rd_addr = best_ff;
         default:    rd_addr = AW'(cand_ff + CW'(1));
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) pmem[wr_addr] <= {req_city_id, req_x_coord, req_y_coord};
      rd_ff <= pmem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:     if (accept && req_last_city) state_in = ST_RSTART;
         ST_RSTART:   state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = ST_SCAN_ACC;
         ST_SCAN_ACC: state_in = (nxt_cand < (CW+1)'(ncity)) ? ST_SCAN_RD : ST_PICK_RD;
         ST_PICK_RD:  state_in = ST_LEG_CMP;
         ST_LEG_CMP:  state_in = ST_SQRT;
         ST_SQRT:     if (step_ff == SCW'(RSTEPS)) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!endr_ff) state_in = ST_SCAN_RD;
            else if (RCW'(route_ff) + RCW'(1) == routes_ff) state_in = ST_LOAD;
            else state_in = ST_RSTART;
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // datapath
   always_comb begin
      vis_in = vis_ff; cnt_in = cnt_ff; depot_in = depot_ff;
      routes_in = routes_ff; route_in = route_ff; cand_in = cand_ff;
      home_in = home_ff; cx_in = cx_ff; cy_in = cy_ff; found_in = found_ff;
      bestd_in = bestd_ff; best_in = best_ff; d_in = d_ff;
      root_in = root_ff; rem_in = rem_ff; val_in = val_ff; step_in = step_ff;
      rsum_in = rsum_ff; tsum_in = tsum_ff; endr_in = endr_ff;
      case (state_ff)
         ST_LOAD: if (accept) begin
            if (depot_ff) begin
               cnt_in = CW'(1); depot_in = 1'b0;
            end else if (cnt_ff < CW'(MAX_POINTS)) cnt_in = cnt_ff + CW'(1);
            if (req_last_city) begin
               routes_in = (nr_eff > NR_W'(MAX_ROUTES)) ? RCW'(MAX_ROUTES) : RCW'(nr_eff);
               route_in = '0; vis_in = '0; tsum_in = '0; depot_in = 1'b1;
               endr_in = 1'b1;
            end
         end
         ST_RSTART: begin
            rsum_in = '0; found_in = 1'b0; endr_in = 1'b0; home_in = 1'b1;
            cand_in = CW'(route_ff);
         end
         ST_SCAN_RD: begin
            // depot position of a new route, read in ST_RSTART
            if (home_ff) begin
               cx_in = $signed(rd_ff[2*COORD_WIDTH-1:COORD_WIDTH]);
               cy_in = $signed(rd_ff[COORD_WIDTH-1:0]);
               home_in = 1'b0;
            end
         end
         ST_SCAN_CMP: d_in = dsq;
         ST_SCAN_ACC: begin
            if (cand_ff < ncity && !vis_ff[AW'(cand_ff + CW'(1))] &&
                (!found_ff || d_ff < bestd_ff)) begin
               found_in = 1'b1; bestd_in = d_ff; best_in = AW'(cand_ff + CW'(1));
            end
            if (nxt_cand < (CW+1)'(ncity)) cand_in = CW'(nxt_cand);
         end
         ST_PICK_RD: begin
            // no city left: the leg goes back to the depot
            if (found_ff) vis_in[best_ff] = 1'b1;
            else begin
               best_in = '0; endr_in = 1'b1;
            end
         end
         ST_LEG_CMP: begin
            val_in = VW'(dsq);
            root_in = '0; rem_in = '0; step_in = '0;
         end
         ST_SQRT: begin
            if (step_ff != SCW'(RSTEPS)) begin
               if (rem_sh >= trial) begin
                  rem_in = rem_sh - trial; root_in = {root_ff[RTW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh; root_in = {root_ff[RTW-2:0], 1'b0};
               end
               val_in = val_ff << 2;
               step_in = step_ff + SCW'(1);
            end else begin
               // sums update when the root is done
               rsum_in = radd[SUM_W] ? SUM_MAX : radd[SUM_W-1:0];
               tsum_in = tadd[SUM_W] ? SUM_MAX : tadd[SUM_W-1:0];
            end
         end
         ST_EMIT: begin
            cx_in = $signed(rd_ff[2*COORD_WIDTH-1:COORD_WIDTH]);
            cy_in = $signed(rd_ff[COORD_WIDTH-1:0]);
            found_in = 1'b0; cand_in = CW'(route_ff);
            if (endr_ff) route_in = route_ff + RW'(1);
         end
         default: ;
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff <= '0;
         depot_ff <= 1'b1;
         nr_ff <= NR_W'(1);
         vis_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         depot_ff <= depot_in;
         vis_ff <= vis_in;
         if (csr_we) nr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      routes_ff <= routes_in; route_ff <= route_in; cand_ff <= cand_in;
      home_ff <= home_in; cx_ff <= cx_in; cy_ff <= cy_in; found_ff <= found_in;
      bestd_ff <= bestd_in; best_ff <= best_in; d_ff <= d_in;
      root_ff <= root_in; rem_ff <= rem_in; val_ff <= val_in; step_ff <= step_in;
      rsum_ff <= rsum_in; tsum_ff <= tsum_in; endr_ff <= endr_in;
   end

   // result word: memory read of the chosen slot lands in ST_EMIT
   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_route_index  = RIDX_W'(route_ff);
   assign rsp_visit_id     = rd_ff[PW-1:2*COORD_WIDTH];
   assign rsp_leg_length   = leg;
   assign rsp_route_length = rsum_ff;
   assign rsp_total_length = tsum_ff;
   assign rsp_end_of_route = endr_ff;
   assign rsp_last         = endr_ff && (RCW'(route_ff) + RCW'(1) == routes_ff);

endmodule

@@ sim/multi_route_nearest_neighbor_tb.sv @@
module multi_route_nearest_neighbor_tb;
   import mrnn_pkg::*;

   localparam int NPTS      = 32;
   localparam int NROUTES   = 8;
   localparam int LIMIT     = 2000000;
   localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

   // one result word
   typedef struct packed {
      logic [RIDX_W-1:0] route_index;
      logic [ID_W-1:0]   visit_id;
      logic [LEG_W-1:0]  leg_length;
      logic [SUM_W-1:0]  route_length;
      logic [SUM_W-1:0]  total_length;
      logic              end_of_route;
      logic              last;
   } visit_type;

   // tour planner: loads points and predicts the visit words of a set
   class tour_board;
      logic signed [15:0] xs[NPTS];
      logic signed [15:0] ys[NPTS];
      logic [ID_W-1:0]    ids[NPTS];
      int                 loaded;
      bit                 loading_cities;
      logic [NR_W-1:0]    routes_reg;
      visit_type          pending[$];
      int                 errors;

      function void clear();
         loaded = 0;
         loading_cities = 0;
         routes_reg = 1;
         pending.delete();
         errors = 0;
      endfunction

      function logic [63:0] sq_dist(int a, int b);
         longint dx, dy;
         dx = longint'(xs[a]) - longint'(xs[b]);
         dy = longint'(ys[a]) - longint'(ys[b]);
         return dx * dx + dy * dy;
      endfunction

      // floor(sqrt(v) * 256)
      function logic [LEG_W-1:0] fixed_root(logic [63:0] v);
         logic [63:0] root, rem, trial, pair;
         root = 0;
         rem = 0;
         for (int k = 31; k >= -8; k--) begin
            pair = (k >= 0) ? ((v >> (2 * k)) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
               rem = rem - trial;
               root = (root << 1) | 64'd1;
            end else begin
               root = root << 1;
            end
         end
         return root[LEG_W-1:0];
      endfunction

      function logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [LEG_W-1:0] b);
         logic [SUM_W:0] s;
         s = a + b;
         return s > SUM_SAT ? SUM_SAT : s[SUM_W-1:0];
      endfunction

      // note an accepted input word
      function void note_point(logic [ID_W-1:0] id, logic signed [15:0] x,
                               logic signed [15:0] y, logic fin);
         int nr, ncity, cur, best, left;
         bit seen[NPTS];
         bit found;
         logic [63:0] d, bestd;
         logic [LEG_W-1:0] leg;
         logic [SUM_W-1:0] rsum, tsum;
         visit_type v;
         if (!loading_cities) begin
            xs[0] = x; ys[0] = y; ids[0] = id;
            loaded = 1;
            loading_cities = 1;
         end else if (loaded < NPTS) begin
            xs[loaded] = x; ys[loaded] = y; ids[loaded] = id;
            loaded++;
         end
         if (!fin) return;
         nr = (routes_reg == 0) ? 1 : (routes_reg > NROUTES ? NROUTES : routes_reg);
         ncity = loaded - 1;
         foreach (seen[i]) seen[i] = 0;
         tsum = 0;
         for (int r = 0; r < nr; r++) begin
            cur = 0;
            rsum = 0;
            left = 0;
            for (int i = r; i < ncity; i += nr) left++;
            // greedy nearest neighbor; strict less keeps the earliest on a tie
            while (left > 0) begin
               found = 0; best = 0; bestd = 0;
               for (int i = r; i < ncity; i += nr) begin
                  if (!seen[i+1]) begin
                     d = sq_dist(cur, i + 1);
                     if (!found || d < bestd) begin
                        found = 1; bestd = d; best = i + 1;
                     end
                  end
               end
               seen[best] = 1;
               leg = fixed_root(sq_dist(cur, best));
               rsum = sat_sum(rsum, leg);
               tsum = sat_sum(tsum, leg);
               cur = best;
               v = '{r[RIDX_W-1:0], ids[best], leg, rsum, tsum, 1'b0, 1'b0};
               pending = {pending, v};
               left--;
            end
            // return leg to the depot
            leg = fixed_root(sq_dist(cur, 0));
            rsum = sat_sum(rsum, leg);
            tsum = sat_sum(tsum, leg);
            v = '{r[RIDX_W-1:0], ids[0], leg, rsum, tsum, 1'b1, 1'(r + 1 == nr)};
            pending = {pending, v};
         end
         loading_cities = 0;
         loaded = 0;
      endfunction

      // compare one visit word with the oldest expectation
      function void check_visit(visit_type got, longint t);
         visit_type exp_v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected visit word %p", t, got);
            errors++;
            return;
         end
         exp_v = pending.pop_front();
         if (got.route_index !== exp_v.route_index)
            $display("%0t: route_index exp %0d got %0d", t, exp_v.route_index, got.route_index);
         if (got.visit_id !== exp_v.visit_id)
            $display("%0t: visit_id exp %0d got %0d", t, exp_v.visit_id, got.visit_id);
         if (got.leg_length !== exp_v.leg_length)
            $display("%0t: leg_length exp %0d got %0d", t, exp_v.leg_length, got.leg_length);
         if (got.route_length !== exp_v.route_length)
            $display("%0t: route_length exp %0d got %0d", t, exp_v.route_length,
                     got.route_length);
         if (got.total_length !== exp_v.total_length)
            $display("%0t: total_length exp %0d got %0d", t, exp_v.total_length,
                     got.total_length);
         if (got.end_of_route !== exp_v.end_of_route)
            $display("%0t: end_of_route exp %0d got %0d", t, exp_v.end_of_route,
                     got.end_of_route);
         if (got.last !== exp_v.last)
            $display("%0t: last exp %0d got %0d", t, exp_v.last, got.last);
         if (got !== exp_v) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [ID_W-1:0] req_city_id = 0;
   logic signed [15:0] req_x_coord = 0;
   logic signed [15:0] req_y_coord = 0;
   logic req_last_city = 0;
   logic csr_we = 0;
   logic [NR_W-1:0] csr_wdata = 0;
   logic rsp_valid;
   wire visit_type rsp;

   tour_board board = new();
   int idle_pct = 0;
   longint cycles = 0;

   multi_route_nearest_neighbor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_city_id(req_city_id), .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord), .req_last_city(req_last_city),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_route_index(rsp.route_index),
      .rsp_visit_id(rsp.visit_id), .rsp_leg_length(rsp.leg_length),
      .rsp_route_length(rsp.route_length), .rsp_total_length(rsp.total_length),
      .rsp_end_of_route(rsp.end_of_route), .rsp_last(rsp.last)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) board.check_visit(rsp, $time);
      if (cycles > LIMIT) begin
         $display("** multi_route_nearest_neighbor: FAILED **");
         $finish;
      end
   end

   // send one point; waits for acceptance, start drops after the last word of a set
   task automatic send_point(logic [ID_W-1:0] id, logic signed [15:0] x,
                             logic signed [15:0] y, logic fin);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_city_id <= id;
      req_x_coord <= x;
      req_y_coord <= y;
      req_last_city <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_point(id, x, y, fin);
      if (fin) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   // wait for the set to drain, then write the route count
   task automatic set_routes(logic [NR_W-1:0] n);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 0;
      board.routes_reg = n;
   endtask

   function automatic logic signed [15:0] rnd_coord(bit wide);
      return wide ? 16'($urandom) : 16'($urandom_range(200) - 100);
   endfunction

   // a set: depot plus ncity cities, random content
   task automatic send_set(int ncity, bit wide);
      send_point(5'($urandom), rnd_coord(wide), rnd_coord(wide), ncity == 0);
      for (int i = 1; i <= ncity; i++)
         send_point(5'($urandom), rnd_coord(wide), rnd_coord(wide), i == ncity);
   endtask

   initial begin
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: depot alone, extremes, ties, overflow of points
      send_point(5'd31, 16'sh7fff, -16'sh8000, 1);
      send_point(5'd0, -16'sh8000, -16'sh8000, 0);
      send_point(5'd31, 16'sh7fff, 16'sh7fff, 0);
      send_point(5'd1, 16'sh7fff, -16'sh8000, 0);
      send_point(5'd2, -16'sh8000, 16'sh7fff, 1);
      set_routes(4'd3);
      // equal distances, earliest wins
      send_point(5'd7, 0, 0, 0);
      send_point(5'd8, 3, 4, 0);
      send_point(5'd9, 1, 1, 0);
      send_point(5'd10, -4, 3, 0);
      send_point(5'd11, 0, 5, 1);
      set_routes(4'd0);
      send_set(3, 1);
      set_routes(4'd15);
      send_set(2, 0);
      set_routes(4'd8);
      send_set(40, 1);  // beyond capacity, dropped cities
      set_routes(4'd1);
      send_set(31, 1);

      // random phases
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 18 : (ph == 1 ? 77 : 0);
         for (int k = 0; k < 5; k++) begin
            set_routes(4'($urandom_range(k == 0 ? 15 : 9)));
            send_set($urandom_range(99) < 10 ? $urandom_range(31, 35)
                                             : $urandom_range(0, 8),
                     $urandom_range(1));
         end
      end
      idle_pct = 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("** multi_route_nearest_neighbor: PASSED **");
      else
         $display("** multi_route_nearest_neighbor: FAILED **");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/mrnn_pkg.sv
rtl/core/multi_route_nearest_neighbor.sv
sim/multi_route_nearest_neighbor_tb.sv
